>>> rtl/cnlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlc_pkg
// Shared types, constants and arithmetic helpers for the card number Luhn
// classifier: brand codes, controller states, controller commands and the
// divide-by-ten step used by the digit peeling datapath.
// ----------------------------------------------------------------------------
package cnlc_pkg;

  localparam int CARD_W         = 54;
  localparam int HALF_W         = 27;
  localparam int DIV_W          = 32;
  localparam int DIG_W          = 4;
  localparam int CNT_W          = 5;
  localparam int LEAD_W         = 7;
  localparam int BRAND_W        = 2;
  localparam int MAX_DIGITS_DEF = 16;

  // x / 10 == (x * RECIP) >> RECIP_SH for every 32-bit x
  localparam logic [DIV_W-1:0] RECIP    = 32'hCCCC_CCCD;
  localparam int               RECIP_SH = 35;

  localparam logic [CNT_W-1:0]  LEN_AMEX  = 5'd15;
  localparam logic [CNT_W-1:0]  LEN_16    = 5'd16;
  localparam logic [CNT_W-1:0]  LEN_13    = 5'd13;
  localparam logic [LEAD_W-1:0] AMEX_LO   = 7'd34;
  localparam logic [LEAD_W-1:0] AMEX_HI   = 7'd37;
  localparam logic [LEAD_W-1:0] MC_MIN    = 7'd51;
  localparam logic [LEAD_W-1:0] MC_MAX    = 7'd55;
  localparam logic [LEAD_W-1:0] VISA_MIN  = 7'd40;
  localparam logic [LEAD_W-1:0] VISA_MAX  = 7'd49;
  localparam logic [DIG_W-1:0]  TEN       = 4'd10;

  typedef enum logic [BRAND_W-1:0] {
    BRAND_INVALID    = 2'd0,
    BRAND_AMEX       = 2'd1,
    BRAND_MASTERCARD = 2'd2,
    BRAND_VISA       = 2'd3
  } brand_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic hi_en;
    logic lo_en;
    logic acc_en;
    logic finish;
  } cmd_t;

  // quotient of a value below 10 * 2**HALF_W by ten
  function automatic logic [HALF_W-1:0] div10(input logic [DIV_W-1:0] x);
    logic [2*DIV_W-1:0] prod;
    begin
      prod = (2*DIV_W)'(x) * (2*DIV_W)'(RECIP);
      return HALF_W'(prod >> RECIP_SH);
    end
  endfunction

  // remainder from dividend and quotient, only the low bits matter
  function automatic logic [DIG_W-1:0] rem10(input logic [DIV_W-1:0] x,
                                             input logic [HALF_W-1:0] q);
    logic [DIG_W+2:0] q10;
    begin
      q10 = {3'b000, q[DIG_W-1:0]} * 7'd10;
      return x[DIG_W-1:0] - q10[DIG_W-1:0];
    end
  endfunction

  // digit sum of twice a decimal digit
  function automatic logic [DIG_W-1:0] luhn_dbl(input logic [DIG_W-1:0] d);
    logic [DIG_W:0] tw;
    begin
      tw = {d, 1'b0};
      if (d >= 4'd5) begin
        tw = tw - 5'd9;
      end
      return tw[DIG_W-1:0];
    end
  endfunction

  function automatic brand_t pick_brand(input logic [CNT_W-1:0] cnt,
                                        input logic [LEAD_W-1:0] lead,
                                        input logic ok);
    brand_t b;
    begin
      b = BRAND_INVALID;
      priority if (!ok) begin
        b = BRAND_INVALID;
      end else if (cnt == LEN_AMEX && (lead == AMEX_LO || lead == AMEX_HI)) begin
        b = BRAND_AMEX;
      end else if (cnt == LEN_16 && lead >= MC_MIN && lead <= MC_MAX) begin
        b = BRAND_MASTERCARD;
      end else if ((cnt == LEN_13 || cnt == LEN_16) && lead >= VISA_MIN
                   && lead <= VISA_MAX) begin
        b = BRAND_VISA;
      end else begin
        b = BRAND_INVALID;
      end
      return b;
    end
  endfunction

endpackage

>>> rtl/cnlc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlc_ctrl
// Controller: takes an item, sequences the skewed divide, digit and
// accumulate steps over the datapath, and owns the result valid flag.
// ----------------------------------------------------------------------------
module cnlc_ctrl #(
  parameter int MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output cnlc_pkg::cmd_t cmd
);

  localparam logic [cnlc_pkg::CNT_W-1:0] HI_END = cnlc_pkg::CNT_W'(MAX_DIGITS);
  localparam logic [cnlc_pkg::CNT_W-1:0] LAST   = cnlc_pkg::CNT_W'(MAX_DIGITS + 1);

  cnlc_pkg::state_t              state_r, state_nxt;
  logic [cnlc_pkg::CNT_W-1:0]    step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      cnlc_pkg::ST_IDLE: begin
        step_nxt = '0;
        if (in_valid) begin
          state_nxt = cnlc_pkg::ST_RUN;
        end
      end
      cnlc_pkg::ST_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LAST) begin
          state_nxt = cnlc_pkg::ST_DONE;
        end
      end
      cnlc_pkg::ST_DONE: begin
        if (slot_free) begin
          state_nxt = cnlc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cnlc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      cnlc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      cnlc_pkg::ST_RUN: begin
        cmd.hi_en  = step_r < HI_END;
        cmd.lo_en  = step_r != '0 && step_r <= HI_END;
        cmd.acc_en = step_r >= 5'd2;
      end
      cnlc_pkg::ST_DONE: begin
        cmd.finish = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cnlc_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/cnlc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnlc_dpath
// Datapath: peels decimal digits with a split divide-by-ten (high half one
// step ahead of the low half), accumulates the Luhn sum modulo ten, tracks
// count and leading digits, and holds the result register.
// ----------------------------------------------------------------------------
module cnlc_dpath #(
  parameter int MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  cnlc_pkg::cmd_t                cmd,
  input  logic [cnlc_pkg::CARD_W-1:0]   in_card_number,
  output logic [cnlc_pkg::BRAND_W-1:0]  out_brand,
  output logic                          out_luhn_ok,
  output logic [cnlc_pkg::CNT_W-1:0]    out_digit_count,
  output logic [cnlc_pkg::LEAD_W-1:0]   out_leading_two
);

  localparam int HW = cnlc_pkg::HALF_W;
  localparam int DW = cnlc_pkg::DIG_W;
  localparam int CW = cnlc_pkg::CNT_W;
  localparam int LW = cnlc_pkg::LEAD_W;
  localparam logic [CW-1:0] OVER_CNT = CW'(MAX_DIGITS + 1);

  // high half divide
  logic [HW-1:0] h_r, h_nxt;
  logic [DW-1:0] rh_r, rh_nxt;
  logic          hnz_r, hnz_nxt;
  // low half divide
  logic [HW-1:0] l_r, l_nxt;
  logic [DW-1:0] dig_r, dig_nxt;
  logic          nz_r, nz_nxt;
  // accumulate
  logic [DW-1:0] sum_r, sum_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] top_r, top_nxt;
  logic [DW-1:0] below_r, below_nxt;
  // result
  logic [cnlc_pkg::BRAND_W-1:0] brand_r, brand_nxt;
  logic                         ok_r, ok_nxt;
  logic [CW-1:0]                dcnt_r, dcnt_nxt;
  logic [LW-1:0]                lead_r, lead_nxt;

  logic [cnlc_pkg::DIV_W-1:0] hx, lx;
  logic [HW-1:0]              hq, lq;
  logic [DW-1:0]              add_v;
  logic [DW:0]                sum_t;
  logic [LW-1:0]              lead_v;
  logic                       ok_v, over;

  assign hx = cnlc_pkg::DIV_W'(h_r);
  assign lx = cnlc_pkg::DIV_W'({rh_r, l_r});
  assign hq = cnlc_pkg::div10(hx);
  assign lq = cnlc_pkg::div10(lx);

  always_comb begin
    h_nxt   = h_r;
    rh_nxt  = rh_r;
    hnz_nxt = hnz_r;
    l_nxt   = l_r;
    dig_nxt = dig_r;
    nz_nxt  = nz_r;
    if (cmd.load) begin
      h_nxt = in_card_number[cnlc_pkg::CARD_W-1:HW];
      l_nxt = in_card_number[HW-1:0];
    end else begin
      if (cmd.hi_en) begin
        h_nxt   = hq;
        rh_nxt  = cnlc_pkg::rem10(hx, hq);
        hnz_nxt = h_r != '0;
      end
      if (cmd.lo_en) begin
        l_nxt   = lq;
        dig_nxt = cnlc_pkg::rem10(lx, lq);
        nz_nxt  = hnz_r || (l_r != '0);
      end
    end
  end

  // luhn sum kept modulo ten
  assign add_v = cnt_r[0] ? cnlc_pkg::luhn_dbl(dig_r) : dig_r;
  assign sum_t = {1'b0, sum_r} + {1'b0, add_v};

  always_comb begin
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    top_nxt   = top_r;
    below_nxt = below_r;
    if (cmd.load) begin
      sum_nxt   = '0;
      cnt_nxt   = '0;
      top_nxt   = '0;
      below_nxt = '0;
    end else if (cmd.acc_en && nz_r) begin
      sum_nxt   = (sum_t >= {1'b0, cnlc_pkg::TEN}) ? DW'(sum_t - {1'b0, cnlc_pkg::TEN})
                                                   : DW'(sum_t);
      cnt_nxt   = cnt_r + 1'b1;
      top_nxt   = dig_r;
      below_nxt = top_r;
    end
  end

  assign over   = (h_r != '0) || (l_r != '0);
  assign ok_v   = sum_r == '0;
  assign lead_v = (cnt_r >= 5'd2) ? LW'({top_r, 3'b000}) + LW'({top_r, 1'b0})
                                    + LW'(below_r)
                                  : LW'(top_r);

  always_comb begin
    brand_nxt = brand_r;
    ok_nxt    = ok_r;
    dcnt_nxt  = dcnt_r;
    lead_nxt  = lead_r;
    if (cmd.finish) begin
      if (over) begin
        brand_nxt = cnlc_pkg::BRAND_INVALID;
        ok_nxt    = 1'b0;
        dcnt_nxt  = OVER_CNT;
        lead_nxt  = '0;
      end else begin
        brand_nxt = cnlc_pkg::pick_brand(cnt_r, lead_v, ok_v);
        ok_nxt    = ok_v;
        dcnt_nxt  = cnt_r;
        lead_nxt  = lead_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r     <= h_nxt;
    rh_r    <= rh_nxt;
    hnz_r   <= hnz_nxt;
    l_r     <= l_nxt;
    dig_r   <= dig_nxt;
    nz_r    <= nz_nxt;
    sum_r   <= sum_nxt;
    cnt_r   <= cnt_nxt;
    top_r   <= top_nxt;
    below_r <= below_nxt;
    brand_r <= brand_nxt;
    ok_r    <= ok_nxt;
    dcnt_r  <= dcnt_nxt;
    lead_r  <= lead_nxt;
  end

  assign out_brand       = brand_r;
  assign out_luhn_ok     = ok_r;
  assign out_digit_count = dcnt_r;
  assign out_leading_two = lead_r;

endmodule

>>> rtl/card_number_luhn_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_core
// Card number classifier: digit count, leading two digits, Luhn check and
// brand code of a binary card number.
//
//   channel  ports                                   direction  width
//   in       in_valid in_stall in_card_number        in         54
//   out      out_valid out_stall out_brand           out        2
//            out_luhn_ok out_digit_count             out        1 5
//            out_leading_two                         out        7
//
// an item goes through an accept step, then divide-by-ten steps over its
// digits with the low half skewed behind the high half, then a result
// step
// one item is in work at a time; the next transfer is taken while the
// previous result still waits in the output register
// synchronous active-low reset clears the controller and the result valid
// ----------------------------------------------------------------------------
module card_number_luhn_classifier_core #(
  parameter int MAX_DIGITS = cnlc_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cnlc_pkg::CARD_W-1:0]   in_card_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cnlc_pkg::BRAND_W-1:0]  out_brand,
  output logic                          out_luhn_ok,
  output logic [cnlc_pkg::CNT_W-1:0]    out_digit_count,
  output logic [cnlc_pkg::LEAD_W-1:0]   out_leading_two
);

  cnlc_pkg::cmd_t cmd;

  cnlc_ctrl #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cnlc_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk             (clk),
    .cmd             (cmd),
    .in_card_number  (in_card_number),
    .out_brand       (out_brand),
    .out_luhn_ok     (out_luhn_ok),
    .out_digit_count (out_digit_count),
    .out_leading_two (out_leading_two)
  );

endmodule
